// ===== src/aip_pkg.sv =====
package aip_pkg;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_SYNTAX   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Mode register codes; the hex code and the unused fourth code share bit 1.
  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam int         MODE_HEX_BIT = 1;

  localparam int VALUE_W = 64;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_string;
  } aip_item_t;

  // Finished string: magnitude, sign and status before the final negation.
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               is_neg;
    logic [1:0]         status;
  } aip_res_t;

endpackage

// ===== src/aip_core.sv =====
module aip_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         parse_mode,
  input  logic               item_valid,
  input  aip_pkg::aip_item_t item,
  output logic               item_ready,
  output logic               res_valid,
  output aip_pkg::aip_res_t  res,
  input  logic               res_ready
);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;

  // Quotient and remainder of each decimal limit by ten.
  localparam logic [63:0] U_LIM_DIV10 = 64'd1844674407370955161;
  localparam logic [3:0]  U_LIM_MOD10 = 4'd5;
  localparam logic [63:0] S_LIM_DIV10 = 64'd922337203685477580;
  localparam logic [3:0]  S_POS_MOD10 = 4'd7;
  localparam logic [3:0]  S_NEG_MOD10 = 4'd8;

  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        first_r, first_nxt;
  logic        digit_r, digit_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        hex_mode, sgn_mode, consume;
  logic [4:0]  dval;
  logic [63:0] lim_q;
  logic [3:0]  lim_r;
  logic [63:0] acc_x10;

  // Digit value, or 16 when the byte is no digit in this base.
  function automatic logic [4:0] digit_value(input logic [7:0] c, input logic hex);
    logic [4:0] v;
    v = 5'd16;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = 5'(c - CHAR_ZERO);
    end else if (hex && c >= CHAR_UA && c <= CHAR_UF) begin
      v = 5'(c - CHAR_UA) + 5'd10;
    end else if (hex && c >= CHAR_LA && c <= CHAR_LF) begin
      v = 5'(c - CHAR_LA) + 5'd10;
    end
    return v;
  endfunction

  assign hex_mode   = parse_mode[aip_pkg::MODE_HEX_BIT];
  assign sgn_mode   = (parse_mode == aip_pkg::MODE_SDEC);
  assign item_ready = !item.end_of_string || res_ready;
  assign consume    = item_valid && item_ready;
  assign res_valid  = item_valid && item.end_of_string;
  assign dval       = digit_value(item.char_code, hex_mode);
  assign acc_x10    = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, dval[3:0]};

  always_comb begin
    if (!sgn_mode) begin
      lim_q = U_LIM_DIV10;
      lim_r = U_LIM_MOD10;
    end else if (neg_r) begin
      lim_q = S_LIM_DIV10;
      lim_r = S_NEG_MOD10;
    end else begin
      lim_q = S_LIM_DIV10;
      lim_r = S_POS_MOD10;
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    digit_nxt = digit_r;
    err_nxt   = err_r;
    if (item.has_char) begin
      first_nxt = 1'b0;
      if (err_r != aip_pkg::ST_OK) begin
        // Bytes after the first error are dropped.
      end else if (sgn_mode && first_r && item.char_code == CHAR_MINUS) begin
        neg_nxt = 1'b1;
      end else if (dval[4]) begin
        err_nxt = aip_pkg::ST_SYNTAX;
      end else if (hex_mode) begin
        if (acc_r[63:60] != 4'd0) begin
          err_nxt = aip_pkg::ST_OVERFLOW;
        end else begin
          acc_nxt   = {acc_r[59:0], dval[3:0]};
          digit_nxt = 1'b1;
        end
      end else begin
        if (acc_r > lim_q || (acc_r == lim_q && dval[3:0] > lim_r)) begin
          err_nxt = aip_pkg::ST_OVERFLOW;
        end else begin
          acc_nxt   = acc_x10;
          digit_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (err_nxt != aip_pkg::ST_OK) begin
      res.status = err_nxt;
    end else if (!digit_nxt) begin
      res.status = aip_pkg::ST_EMPTY;
    end else begin
      res.status = aip_pkg::ST_OK;
    end
    res.mag    = (res.status == aip_pkg::ST_OK) ? acc_nxt : '0;
    res.is_neg = (res.status == aip_pkg::ST_OK) && neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      first_r <= 1'b1;
      digit_r <= 1'b0;
      err_r   <= aip_pkg::ST_OK;
    end else if (consume) begin
      if (item.end_of_string) begin
        acc_r   <= '0;
        neg_r   <= 1'b0;
        first_r <= 1'b1;
        digit_r <= 1'b0;
        err_r   <= aip_pkg::ST_OK;
      end else begin
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        first_r <= first_nxt;
        digit_r <= digit_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    consume && item.end_of_string |=> first_r && !digit_r && err_r == aip_pkg::ST_OK)
    else $error("string state not cleared after its last item");

  a_digit_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    digit_r |-> !first_r)
    else $error("digit recorded while no byte seen");

  a_err_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != aip_pkg::ST_EMPTY)
    else $error("empty code stored as a sticky error");

  a_err_freezes_acc: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != aip_pkg::ST_OK && !(consume && item.end_of_string) |=> $stable(acc_r))
    else $error("accumulator changed after an error");

endmodule

// ===== src/aip_out.sv =====
module aip_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  aip_pkg::aip_res_t res,
  output logic              res_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata
);

  logic                      s1_valid_r, s1_valid_nxt;
  aip_pkg::aip_res_t         s1_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [aip_pkg::VALUE_W-1:0] out_value_r, value_nxt;
  logic [1:0]                out_status_r;
  logic                      s2_ready;

  assign s2_ready  = !out_valid_r || out_tready;
  assign res_ready = !s1_valid_r || s2_ready;

  // Two's complement is applied one stage after the parse update.
  assign value_nxt = s1_r.is_neg ? (aip_pkg::VALUE_W'(0) - s1_r.mag) : s1_r.mag;

  assign s1_valid_nxt  = res_valid || (s1_valid_r && !s2_ready);
  assign out_valid_nxt = s1_valid_r || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_ready) begin
        s1_valid_r <= res_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      s1_r <= res;
    end
    if (s2_ready && s1_valid_r) begin
      out_value_r  <= value_nxt;
      out_status_r <= s1_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_value_r};

  a_next_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_nxt == ((res_ready && res_valid) || (!res_ready && s1_valid_r)))
    else $error("result stage valid update inconsistent");

  a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt == ((s2_ready && s1_valid_r) || (!s2_ready && out_valid_r)))
    else $error("output stage valid update inconsistent");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != aip_pkg::ST_OK |-> out_value_r == '0)
    else $error("nonzero value with an error status");

endmodule

// ===== src/ascii_integer_parser.sv =====
// Streaming ASCII integer parser.
// A string arrives on the in_ channel one byte per item; in_tuser flags a
// valid byte and in_tlast marks the last item of the string. One result
// item leaves on the out_ channel for every string: the 64-bit value and
// a status (ok, empty, bad syntax, overflow). An item with in_tuser low and
// in_tlast low changes nothing.
// cfg_wr_en writes cfg_wr_data into the mode register (0 unsigned decimal,
// 1 signed decimal, 2 or 3 hexadecimal); write it only while no string is
// in flight.
// A result passes through the input register, the result stage and the output
// stage. Input items are taken one per cycle while in_tready is high; the
// multiply-by-ten, compare and add on the accumulator are combinational.
// Reset clears the mode to unsigned decimal, empties all stages and starts
// a new string. When out_tready is low, results stay in the output and
// result stages; input items keep being parsed until a string end needs the
// result stage, then in_tready drops until it frees.
module ascii_integer_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,    // parse_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // char_code
  input  logic        in_tuser,       // has_char
  input  logic        in_tlast,       // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata       // result_value [63:0], status [65:64], zero
);

  logic               mode_r;
  logic [1:0]         parse_mode_r;
  logic               in_valid_r;
  aip_pkg::aip_item_t in_item_r;
  logic               core_ready;
  logic               res_valid;
  logic               res_ready;
  aip_pkg::aip_res_t  res;

  assign mode_r    = parse_mode_r[aip_pkg::MODE_HEX_BIT];
  assign in_tready = !in_valid_r || core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_mode_r <= aip_pkg::MODE_UDEC;
      in_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        parse_mode_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.char_code     <= in_tdata;
      in_item_r.has_char      <= in_tuser;
      in_item_r.end_of_string <= in_tlast;
    end
  end

  aip_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .parse_mode (parse_mode_r),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .item_ready (core_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  aip_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_hex_mode_bit: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> parse_mode_r != aip_pkg::MODE_UDEC && parse_mode_r != aip_pkg::MODE_SDEC)
    else $error("hex mode decode inconsistent");

endmodule

// ===== tb/tb_ascii_integer_parser.sv =====
module tb_ascii_integer_parser;

  localparam logic [1:0] MODE_HEX_ALT = 2'd3;  // bit 1 set, so also hexadecimal
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  typedef logic [7:0] text_t[$];

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
  } number_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // char_code
  logic        in_tuser;   // has_char
  logic        in_tlast;   // end_of_string
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // result_value [63:0], status [65:64], zero

  // Parser state as the block should hold it.
  logic [1:0]  parse_mode_now;
  logic [63:0] acc_mag;
  logic        minus_seen;
  logic        first_pending;
  logic        any_digit;
  logic [1:0]  first_err;

  number_t pending_numbers[$];
  int      mismatches;
  int      sent_items;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_left;

  ascii_integer_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_string();
    acc_mag = '0;
    minus_seen = 1'b0;
    first_pending = 1'b1;
    any_digit = 1'b0;
    first_err = aip_pkg::ST_OK;
  endfunction

  // Digit value in the current base, or 16 for a byte that is no digit.
  function automatic logic [4:0] digit_of(logic [7:0] c, logic hex);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (hex && c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (hex && c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'd16;
  endfunction

  function automatic void advance_parser(logic [7:0] c, logic has, logic last);
    logic        hex;
    logic        sgn;
    logic        first;
    logic [4:0]  d;
    logic [63:0] limit;
    number_t     r;
    if (has) begin
      hex = parse_mode_now[aip_pkg::MODE_HEX_BIT];
      sgn = (parse_mode_now == aip_pkg::MODE_SDEC);
      first = first_pending;
      first_pending = 1'b0;
      // Every error code differs from the ok code, so ok doubles as "no error yet".
      if (first_err == aip_pkg::ST_OK) begin
        d = digit_of(c, hex);
        if (sgn && first && c == "-") begin
          minus_seen = 1'b1;
        end else if (d[4]) begin
          first_err = aip_pkg::ST_SYNTAX;
        end else if (hex) begin
          if (acc_mag[63:60] != 4'd0) begin
            first_err = aip_pkg::ST_OVERFLOW;
          end else begin
            acc_mag = {acc_mag[59:0], d[3:0]};
            any_digit = 1'b1;
          end
        end else begin
          if (!sgn) limit = '1;
          else if (minus_seen) limit = 64'h8000_0000_0000_0000;
          else limit = 64'h7FFF_FFFF_FFFF_FFFF;
          if (acc_mag > limit / 10 || (acc_mag == limit / 10 && 64'(d) > limit % 10)) begin
            first_err = aip_pkg::ST_OVERFLOW;
          end else begin
            acc_mag = acc_mag * 10 + 64'(d);
            any_digit = 1'b1;
          end
        end
      end
    end
    if (last) begin
      if (first_err != aip_pkg::ST_OK) begin
        r.value = '0;
        r.status = first_err;
      end else if (!any_digit) begin
        r.value = '0;
        r.status = aip_pkg::ST_EMPTY;
      end else begin
        r.value = minus_seen ? 64'd0 - acc_mag : acc_mag;
        r.status = aip_pkg::ST_OK;
      end
      pending_numbers.push_back(r);
      clear_string();
    end
  endfunction

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch in %s: expected %h, got %h", field, want, got);
  endfunction

  always @(posedge clk) begin
    number_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %h with no string pending", out_tdata[65:0]);
      end else begin
        want = pending_numbers.pop_front();
        if (out_tdata[63:0] !== want.value) note_mismatch("value", want.value, out_tdata[63:0]);
        if (out_tdata[65:64] !== want.status)
          note_mismatch("status", 64'(want.status), 64'(out_tdata[65:64]));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when hold_left is loaded.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(logic [7:0] c, logic has, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= has;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_parser(c, has, last);
    if (has || last) sent_items++;
    @(negedge clk);
  endtask

  // One string, with byteless filler items mixed in; optionally ended by a separate item that carries no byte.
  task automatic send_string(text_t txt, bit separate_end, int filler_pct);
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(99) < filler_pct) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(txt[i], 1'b1, !separate_end && i == txt.size() - 1);
    end
    if (separate_end || txt.size() == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic text_t to_text(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  task automatic send_literal(string s, bit separate_end = 1'b0);
    send_string(to_text(s), separate_end, 0);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_numbers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    parse_mode_now = m;
  endtask

  function automatic text_t dec_text(logic [63:0] v);
    text_t t;
    do begin
      t.push_front(8'("0" + v % 10));
      v = v / 10;
    end while (v != 0);
    return t;
  endfunction

  // Hex digits in random letter case; digits beyond the 64-bit value are random.
  function automatic text_t hex_text(logic [63:0] v, int ndig);
    text_t t;
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      if (i < 16) nib = v[4*i +: 4];
      else nib = 4'($urandom_range(15));
      if (nib < 10) t.push_back(8'("0" + nib));
      else if ($urandom_range(1)) t.push_back(8'("A" + nib - 10));
      else t.push_back(8'("a" + nib - 10));
    end
    return t;
  endfunction

  // Mostly well-formed numbers for the mode, some empty strings and lone minus
  // signs, the rest random bytes.
  function automatic text_t random_text(logic [1:0] m);
    text_t t;
    logic [63:0] v;
    int kind;
    int n;
    string pool;
    pool = "0123456789abcdefABCDEFgG-+ x";
    kind = $urandom_range(99);
    if (kind < 72) begin
      if (m[aip_pkg::MODE_HEX_BIT]) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(18, 17) : $urandom_range(16, 1);
        v = {$urandom, $urandom};
        t = hex_text(v, n);
      end else begin
        case ($urandom_range(3))
          0: v = 64'($urandom_range(999));
          1: v = {$urandom, $urandom} >> $urandom_range(63);
          2: v = (m == aip_pkg::MODE_SDEC) ? 64'h8000_0000_0000_0000 + $urandom_range(4) - 2
                                           : '1 - 64'($urandom_range(4));
          default: v = {$urandom, $urandom};
        endcase
        t = dec_text(v);
        if ($urandom_range(5) == 0) t.push_back(8'("0" + $urandom_range(9)));
        if (m == aip_pkg::MODE_SDEC && $urandom_range(1)) t.push_front("-");
      end
    end else if (kind < 82) begin
      if ($urandom_range(1)) t.push_back("-");
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        if ($urandom_range(1)) t.push_back(8'($urandom_range(255)));
        else t.push_back(pool[$urandom_range(pool.len() - 1)]);
      end
    end
    return t;
  endfunction

  task automatic test_unsigned_decimal();
    set_mode(aip_pkg::MODE_UDEC);
    send_literal("0");
    send_literal("18446744073709551615");
    send_literal("18446744073709551616");
    send_literal("000123", 1'b1);
    send_literal("-5");
    send_literal("1x99999999999999999999999");
    send_literal("184467440737095516160x");
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_signed_decimal();
    set_mode(aip_pkg::MODE_SDEC);
    send_literal("-9223372036854775808");
    send_literal("-9223372036854775809");
    send_literal("9223372036854775807");
    send_literal("9223372036854775808");
    send_literal("-");
    send_literal("-", 1'b1);
    send_literal("5-");
    send_literal("--1");
    send_literal("-0");
  endtask

  task automatic test_hexadecimal();
    set_mode(aip_pkg::MODE_HEX);
    send_literal("FFFFFFFFFFFFFFFF");
    send_literal("aBcDeF0123456789");
    send_literal("10000000000000000");
    send_literal("00000000000000000001");
    send_literal("fg");
    send_literal("-1");
    set_mode(MODE_HEX_ALT);
    send_literal("dEaD");
    send_literal("Z");
  endtask

  // Bytes already taken keep their effect; each new byte follows the new mode.
  task automatic test_mode_change_within_string();
    set_mode(aip_pkg::MODE_UDEC);
    send_item("1", 1'b1, 1'b0);
    send_item("2", 1'b1, 1'b0);
    set_mode(aip_pkg::MODE_HEX);
    send_item("A", 1'b1, 1'b1);
    set_mode(aip_pkg::MODE_SDEC);
    send_item("-", 1'b1, 1'b0);
    set_mode(aip_pkg::MODE_UDEC);
    send_item("5", 1'b1, 1'b1);
  endtask

  task automatic test_random_strings();
    int idle_mix[4][2];
    logic [1:0] modes[4];
    int target;
    idle_mix = '{'{0, 0}, '{56, 0}, '{0, 56}, '{28, 28}};
    modes = '{aip_pkg::MODE_UDEC, aip_pkg::MODE_SDEC, aip_pkg::MODE_HEX, MODE_HEX_ALT};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      for (int k = 0; k < 4; k++) begin
        set_mode(modes[(p + k) % 4]);
        target = sent_items + 50;
        while (sent_items < target)
          send_string(random_text(parse_mode_now), $urandom_range(3) == 0, 8);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off long enough that results back up and stall the input.
  task automatic test_result_backpressure();
    set_mode(aip_pkg::MODE_SDEC);
    hold_left = 300;
    repeat (40) send_string(random_text(parse_mode_now), 1'b0, 0);
    wait_for_results();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = aip_pkg::MODE_UDEC;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    mismatches = 0;
    sent_items = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    parse_mode_now = aip_pkg::MODE_UDEC;
    clear_string();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unsigned_decimal();
    test_signed_decimal();
    test_hexadecimal();
    test_mode_change_within_string();
    test_random_strings();
    test_result_backpressure();

    wait_for_results();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
src/aip_pkg.sv
src/aip_core.sv
src/aip_out.sv
src/ascii_integer_parser.sv
tb/tb_ascii_integer_parser.sv
